/* rtl/core/route_longest_prefix_match_unit_assert.svh */
// Assertion macros shared by the route table checker.
`ifndef ROUTE_LONGEST_PREFIX_MATCH_UNIT_ASSERT_SVH
`define ROUTE_LONGEST_PREFIX_MATCH_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLPM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("route table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RLPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("route table assertion failed");

`endif

/* rtl/core/rlpm_pkg.sv */
// Shared types, opcodes and helper functions of the route lookup unit.
package rlpm_pkg;

    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_PORT_COUNT    = 16;

    localparam logic [1:0] OP_LOOKUP     = 2'd0;
    localparam logic [1:0] OP_WRITE      = 2'd1;
    localparam logic [1:0] OP_INVALIDATE = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  entry_index;
        logic [31:0] entry_dest;
        logic [31:0] entry_mask;
        logic [31:0] entry_gateway;
        logic [3:0]  entry_port;
        logic [31:0] lookup_addr;
    } t_in_word;

    typedef struct packed {
        logic        hit;
        logic [3:0]  match_index;
        logic [31:0] next_hop;
        logic [3:0]  out_port;
    } t_out_word;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic load_out;
    } t_ctl_cmd;

    typedef struct packed {
        logic scan_last;
    } t_ctl_sts;

    function automatic logic [5:0] mask_len(input logic [31:0] mask);
        logic [5:0] sum;
        logic [3:0] nib;
        sum = 6'd0;
        for (int k = 0; k < 8; k++) begin
            nib = mask[4*k +: 4];
            sum = sum + 6'(nib[0]) + 6'(nib[1]) + 6'(nib[2]) + 6'(nib[3]);
        end
        return sum;
    endfunction

endpackage

/* rtl/core/rlpm_datapath.sv */
// Route table storage, sequential match scan and result register.
module rlpm_datapath import rlpm_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int PORT_COUNT    = DEF_PORT_COUNT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctl_cmd  i_cmd,
    output t_ctl_sts  o_sts,
    input  t_in_word  i_in,
    output t_out_word o_out
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [8:0] PORT_MAX = 9'(PORT_COUNT - 1);

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [3:0]  port;
        logic [5:0]  len;
    } t_entry;

    t_entry             r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]   r_cnt;
    logic               r_cmp_en;
    t_entry             r_rd;
    logic               r_rd_valid;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [31:0]        r_addr;
    logic               r_found;
    logic [5:0]         r_best_len;
    logic [IDX_W-1:0]   r_best_idx;
    logic [31:0]        r_best_gw;
    logic [3:0]         r_best_port;
    t_out_word          r_out;

    logic [8:0]         w_idx_ext;
    logic               w_idx_ok;
    logic [IDX_W-1:0]   w_slot;
    logic [3:0]         w_port;
    t_entry             w_entry;
    logic               w_wr_en;
    logic               w_inv_en;
    logic               w_last;
    logic               w_take;
    logic [8:0]         w_best_ext;

    assign w_idx_ext = {5'd0, i_in.entry_index};
    assign w_idx_ok  = w_idx_ext < 9'(TABLE_ENTRIES);
    assign w_slot    = w_idx_ext[IDX_W-1:0];
    assign w_port    = ({5'd0, i_in.entry_port} > PORT_MAX) ? PORT_MAX[3:0]
                                                           : i_in.entry_port;
    assign w_wr_en   = i_cmd.capture && (i_in.opcode == OP_WRITE) && w_idx_ok;
    assign w_inv_en  = i_cmd.capture && (i_in.opcode == OP_INVALIDATE) && w_idx_ok;
    assign w_last    = r_cnt == IDX_W'(TABLE_ENTRIES - 1);
    assign w_take    = r_cmp_en && r_rd_valid
                    && ((r_addr & r_rd.mask) == r_rd.dest)
                    && (!r_found || (r_rd.len >= r_best_len));
    assign w_best_ext = 9'(r_best_idx);

    always_comb begin
        w_entry.dest    = i_in.entry_dest;
        w_entry.mask    = i_in.entry_mask;
        w_entry.gateway = i_in.entry_gateway;
        w_entry.port    = w_port;
        w_entry.len     = mask_len(i_in.entry_mask);
    end

    assign o_sts.scan_last = w_last;
    assign o_out           = r_out;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_slot] <= w_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd       <= r_mem[r_cnt];
            r_rd_valid <= r_valid[r_cnt];
            r_rd_idx   <= r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_cnt    <= '0;
            r_cmp_en <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.rd_en;
            if (w_wr_en) begin
                r_valid[w_slot] <= 1'b1;
            end else if (w_inv_en) begin
                r_valid[w_slot] <= 1'b0;
            end
            if (i_cmd.capture) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.rd_en && !w_last) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (w_take) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr <= i_in.lookup_addr;
        end
        if (w_take) begin
            r_best_len  <= r_rd.len;
            r_best_idx  <= r_rd_idx;
            r_best_gw   <= r_rd.gateway;
            r_best_port <= r_rd.port;
        end
        if (i_cmd.load_out) begin
            r_out.hit         <= r_found;
            r_out.match_index <= r_found ? w_best_ext[3:0] : 4'd0;
            r_out.next_hop    <= r_found ? r_best_gw : 32'd0;
            r_out.out_port    <= r_found ? r_best_port : 4'd0;
        end
    end

endmodule

/* rtl/core/rlpm_controller.sv */
// Controller state machine that sequences table updates, scans and results.
module rlpm_controller import rlpm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_ctl_cmd   o_cmd,
    input  t_ctl_sts   i_sts
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_load;

    assign o_in_ready  = r_state == S_IDLE;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_load      = (r_state == S_RESULT) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    assign o_cmd.capture  = w_accept;
    assign o_cmd.rd_en    = r_state == S_SCAN;
    assign o_cmd.load_out = w_load;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_opcode == OP_LOOKUP) ? S_SCAN : S_RESULT;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/core/route_longest_prefix_match_unit.sv */
// IPv4 longest-prefix-match route table. Each input word writes a slot, invalidates a slot
// or looks up an address, and every word yields exactly one result word. A write, an
// invalidate or an unused opcode goes from acceptance straight to the result state. A lookup
// first scans the table, reading one slot per cycle from the single-ported entry memory, and
// keeps the longest matching mask, with ties going to the higher slot. The result register
// lets a new word be accepted while the previous result still waits. Slot valid bits clear
// at reset; slot contents need no clearing.
module route_longest_prefix_match_unit import rlpm_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int PORT_COUNT    = DEF_PORT_COUNT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out
);

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;

    rlpm_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_in.opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    rlpm_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PORT_COUNT    (PORT_COUNT)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

/* rtl/core/rlpm_checker.sv */
// Port-level checker for the route lookup unit and its bind to the top level.
`include "route_longest_prefix_match_unit_assert.svh"

module rlpm_checker import rlpm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out
);

    `RLPM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `RLPM_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out))
    `RLPM_ASSERT_SAME(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_out.hit, (o_out.match_index == 4'd0) && (o_out.next_hop == 32'd0) && (o_out.out_port == 4'd0))
    `RLPM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind route_longest_prefix_match_unit rlpm_checker u_rlpm_checker (.*);
